// ===== rtl/radio_module_response_parser_top_assert.svh =====
// Assertion macros for the radio module response parser.
// Used by radio_module_response_parser_top; relies on clk_i and rst_ni in scope.
`ifndef RADIO_MODULE_RESPONSE_PARSER_TOP_ASSERT_SVH
`define RADIO_MODULE_RESPONSE_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define RMRP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rmrp assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define RMRP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rmrp assertion failed");

`endif

// ===== rtl/rmrp_pkg.sv =====
// Package for the radio module response parser: sizes, character codes,
// event kinds and the hex digit decoder. No dependencies.
`timescale 1ns / 1ps

package rmrp_pkg;

  // Stored line holds up to LINE_CAP-1 characters.
  localparam int LINE_CAP      = 32;
  localparam int PAYLOAD_LIMIT = 64;

  localparam int LineLenW = $clog2(LINE_CAP);
  localparam int CountW   = 8;

  localparam logic [LineLenW-1:0] LineLast  = LineLenW'(LINE_CAP - 1);
  localparam logic [LineLenW-1:0] HeaderLen = LineLenW'(10);
  localparam logic [CountW-1:0]   PayloadLimit = CountW'(PAYLOAD_LIMIT);
  localparam logic [CountW-1:0]   CountMax  = '1;

  // Character codes.
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch9     = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChO     = 8'h4f;
  localparam logic [7:0] ChK     = 8'h4b;
  localparam logic [7:0] ChN     = 8'h4e;
  localparam logic [7:0] ChG     = 8'h47;

  // Kinds of result item.
  typedef enum logic [2:0] {
    KindByte = 3'd0,
    KindEnd  = 3'd1,
    KindOk   = 3'd2,
    KindNg   = 3'd3,
    KindId   = 3'd4,
    KindNode = 3'd5,
    KindRssi = 3'd6
  } event_kind_e;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // Decodes one hex digit; lower case letters count only when lower_ok is set.
  function automatic hex_t hex_decode(input logic [7:0] c, input logic lower_ok);
    hex_t       r;
    logic [7:0] diff;
    r    = '0;
    diff = '0;
    if (c >= Ch0 && c <= Ch9) begin
      diff  = c - Ch0;
      r.ok  = 1'b1;
      r.val = diff[3:0];
    end else if (c >= ChUpA && c <= ChUpF) begin
      diff  = c - ChUpA + 8'd10;
      r.ok  = 1'b1;
      r.val = diff[3:0];
    end else if (lower_ok && c >= ChLowA && c <= ChLowF) begin
      diff  = c - ChLowA + 8'd10;
      r.ok  = 1'b1;
      r.val = diff[3:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/radio_module_response_parser_top.sv =====
// Response parser for a serial radio module: one received character in, at most
// one event out. Every character is handled in the cycle it is accepted, and its
// event lands in a single output register, so the block takes one item per cycle
// and stalls its input only while a finished event is held by a stalled receiver.
// An event's valid rises in the cycle after its character is accepted. There is no
// clearing pass after reset. Uses rmrp_pkg and radio_module_response_parser_top_assert.svh.
`timescale 1ns / 1ps

module radio_module_response_parser_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration: pending query
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  // character input
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_char_i,
  // event output
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] event_kind_o,
  output logic [15:0] event_value_o,
  output logic       payload_full_o
);

  import rmrp_pkg::*;

  typedef enum logic [1:0] {
    PairHigh = 2'd0,
    PairLow  = 2'd1,
    PairWait = 2'd2
  } pair_phase_e;

  // Parser state.
  logic [1:0]          pending_query_q;
  logic                query_answered_q, query_answered_d;
  logic                in_data_mode_q, in_data_mode_d;
  logic [LineLenW-1:0] line_length_q, line_length_d;
  logic [7:0]          first_char_q, first_char_d;
  logic [7:0]          second_char_q, second_char_d;
  logic                comma_at_two_q, comma_at_two_d;
  logic                comma_at_seven_q, comma_at_seven_d;
  logic [15:0]         hex_acc_q, hex_acc_d;
  logic                hex_run_open_q, hex_run_open_d;
  pair_phase_e         pair_phase_q, pair_phase_d;
  logic [3:0]          high_nibble_q, high_nibble_d;
  logic [CountW-1:0]   byte_count_q, byte_count_d;

  // Output register.
  logic                out_valid_q;
  event_kind_e         kind_q, kind_d;
  logic [15:0]         value_q, value_d;
  logic                full_q, full_d;
  logic                emit;

  logic                accept;
  hex_t                hex_up;
  hex_t                hex_any;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign hex_up     = hex_decode(rx_char_i, 1'b0);
  assign hex_any    = hex_decode(rx_char_i, 1'b1);

  // Per-character update and event formation.
  always_comb begin
    query_answered_d = query_answered_q;
    in_data_mode_d   = in_data_mode_q;
    line_length_d    = line_length_q;
    first_char_d     = first_char_q;
    second_char_d    = second_char_q;
    comma_at_two_d   = comma_at_two_q;
    comma_at_seven_d = comma_at_seven_q;
    hex_acc_d        = hex_acc_q;
    hex_run_open_d   = hex_run_open_q;
    pair_phase_d     = pair_phase_q;
    high_nibble_d    = high_nibble_q;
    byte_count_d     = byte_count_q;
    emit             = 1'b0;
    kind_d           = KindByte;
    value_d          = '0;
    full_d           = 1'b0;

    if (!in_data_mode_q) begin
      if (rx_char_i == ChNul || rx_char_i == ChLf || rx_char_i == ChCr) begin
        // Line end: answer the pending query first, else look for OK or NG.
        line_length_d = '0;
        if (pending_query_q != 2'd0 && !query_answered_q && line_length_q != '0 &&
            first_char_q >= Ch0 && first_char_q <= ChUpF) begin
          query_answered_d = 1'b1;
          emit             = 1'b1;
          kind_d           = event_kind_e'(3'(KindNg) + {1'b0, pending_query_q});
          value_d          = hex_acc_q;
        end else if (line_length_q >= LineLenW'(2) && first_char_q == ChO &&
                     second_char_q == ChK) begin
          emit   = 1'b1;
          kind_d = KindOk;
        end else if (line_length_q >= LineLenW'(2) && first_char_q == ChN &&
                     second_char_q == ChG) begin
          emit   = 1'b1;
          kind_d = KindNg;
        end
      end else if (rx_char_i == ChColon && line_length_q == HeaderLen &&
                   comma_at_two_q && comma_at_seven_q) begin
        // Valid header: switch to data mode and start a new packet.
        in_data_mode_d = 1'b1;
        pair_phase_d   = PairHigh;
        byte_count_d   = '0;
      end else if (line_length_q < LineLast) begin
        // Store the character and extend the leading hex number.
        if (line_length_q == '0) begin
          first_char_d   = rx_char_i;
          hex_run_open_d = hex_up.ok;
          hex_acc_d      = hex_up.ok ? {12'd0, hex_up.val} : 16'd0;
        end else begin
          if (line_length_q == LineLenW'(1)) second_char_d = rx_char_i;
          if (line_length_q == LineLenW'(2)) comma_at_two_d = (rx_char_i == ChComma);
          if (line_length_q == LineLenW'(7)) comma_at_seven_d = (rx_char_i == ChComma);
          if (hex_run_open_q && hex_any.ok) begin
            hex_acc_d = {hex_acc_q[11:0], hex_any.val};
          end else begin
            hex_run_open_d = 1'b0;
          end
        end
        line_length_d = line_length_q + LineLenW'(1);
      end
    end else begin
      if (rx_char_i == ChCr || rx_char_i == ChLf) begin
        // Packet end.
        in_data_mode_d = 1'b0;
        line_length_d  = '0;
        emit           = 1'b1;
        kind_d         = KindEnd;
        full_d         = (byte_count_q >= PayloadLimit);
      end else begin
        // Hex pairs; anything that is not a digit decodes to zero.
        case (pair_phase_q)
          PairHigh: begin
            high_nibble_d = hex_any.ok ? hex_any.val : 4'd0;
            pair_phase_d  = PairLow;
          end
          PairLow: begin
            pair_phase_d = PairWait;
            if (byte_count_q != CountMax) byte_count_d = byte_count_q + CountW'(1);
            emit    = 1'b1;
            kind_d  = KindByte;
            value_d = {8'd0, high_nibble_q, (hex_any.ok ? hex_any.val : 4'd0)};
            full_d  = (byte_count_d >= PayloadLimit);
          end
          default: begin
            if (rx_char_i == ChComma) pair_phase_d = PairHigh;
          end
        endcase
      end
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_query_q  <= '0;
      query_answered_q <= 1'b0;
      in_data_mode_q   <= 1'b0;
      line_length_q    <= '0;
      first_char_q     <= '0;
      second_char_q    <= '0;
      comma_at_two_q   <= 1'b0;
      comma_at_seven_q <= 1'b0;
      hex_acc_q        <= '0;
      hex_run_open_q   <= 1'b0;
      pair_phase_q     <= PairHigh;
      high_nibble_q    <= '0;
      byte_count_q     <= '0;
    end else begin
      if (accept) begin
        query_answered_q <= query_answered_d;
        in_data_mode_q   <= in_data_mode_d;
        line_length_q    <= line_length_d;
        first_char_q     <= first_char_d;
        second_char_q    <= second_char_d;
        comma_at_two_q   <= comma_at_two_d;
        comma_at_seven_q <= comma_at_seven_d;
        hex_acc_q        <= hex_acc_d;
        hex_run_open_q   <= hex_run_open_d;
        pair_phase_q     <= pair_phase_d;
        high_nibble_q    <= high_nibble_d;
        byte_count_q     <= byte_count_d;
      end
      // A register write re-arms the query answer.
      if (cfg_we_i) begin
        pending_query_q  <= cfg_wdata_i;
        query_answered_q <= 1'b0;
      end
    end
  end

  // Output register: loaded by an accepted item that yields an event.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= emit;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      kind_q  <= kind_d;
      value_q <= value_d;
      full_q  <= full_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_kind_o   = kind_q;
  assign event_value_o  = value_q;
  assign payload_full_o = full_q;

  // Checks on the parser's own logic.
`include "radio_module_response_parser_top_assert.svh"

  `RMRP_ASSERT_NOW(a_line_bounded, 1'b1, line_length_q <= LineLast)
  `RMRP_ASSERT_NOW(a_data_after_header, in_data_mode_q, line_length_q == HeaderLen)
  `RMRP_ASSERT_NOW(a_full_only_packet, out_valid_q && kind_q != KindByte && kind_q != KindEnd, !full_q)
  `RMRP_ASSERT_NEXT(a_cfg_rearms, cfg_we_i, !query_answered_q)

endmodule
